FILE: hw/rtl/sinkhorn_matrix_scaler_unit_defines.svh
// Assertion macros shared by the scaler checker
`ifndef SINKHORN_MATRIX_SCALER_UNIT_DEFINES_SVH
`define SINKHORN_MATRIX_SCALER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sms_pkg.sv
// Types and constants of the Sinkhorn matrix scaler
`timescale 1ns / 1ps
package sms_pkg;

    localparam int VAL_W  = 32;
    localparam int SUM_W  = 40;
    localparam int PROD_W = 64;
    localparam int TOL_W  = 48;
    localparam int ITER_W = 16;
    localparam int DIM_W  = 5;
    localparam int IDX_W  = 8;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;
    localparam int FLAT_W = 10;
    localparam int REG_W  = 2;

    localparam logic [MODE_W-1:0] MODE_LD_ENTRY = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LD_ROW   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LD_COL   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RUN      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ     = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_CAP  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BAD  = 2'd3;

    localparam logic [REG_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [REG_W-1:0] REG_COLS  = 2'd1;
    localparam logic [REG_W-1:0] REG_TOL   = 2'd2;
    localparam logic [REG_W-1:0] REG_MAXIT = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
    } item_t;

    typedef struct packed {
        logic [VAL_W-1:0]  result_value;
        logic [ITER_W-1:0] iterations;
        logic [STAT_W-1:0] status;
    } result_t;

    typedef struct packed {
        logic ld_mat;
        logic ld_row;
        logic ld_col;
        logic snap_wr;
        logic sum_clr;
        logic sum_acc;
        logic mul_scale;
        logic mul_sq;
        logic div_start;
        logic mat_wr_q;
        logic err_clr;
        logic err_acc;
        logic col_phase;
        logic show_read;
        logic read_bad;
    } dp_cmd_t;

    typedef struct packed {
        logic sum_zero;
        logic converged;
        logic div_busy;
    } dp_stat_t;

endpackage

FILE: hw/rtl/sinkhorn_matrix_scaler_unit.sv
// Top level of the Sinkhorn-Knopp matrix scaler
//
//  channel   | handshake            | word
//  ----------+----------------------+----------------------------------------
//  command   | start / busy         | item   (mode, index, value)
//  result    | done (strobe)        | result (result_value, iterations, status)
//  config    | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// Loads finish in the cycle they are accepted; busy stays low, so loads can
// follow each other every cycle. A read holds busy through S_READ_RD and
// S_READ_OUT (matrix memory read) and strobes its word in S_READ_OUT.
// A run walks the matrix per iteration: copy (read, write per entry), row and
// column passes (sum: read, accumulate per entry, zero check per line; scale:
// read, multiply, divider start, 32 divide steps, write-back per entry), error
// pass (read, square, accumulate per entry), convergence test; divider sets pace.
// Reset sets control, config defaults and sums; stores undefined until loaded.
// The result strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps
module sinkhorn_matrix_scaler_unit #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  sms_pkg::item_t             item,
    output logic                       done,
    output sms_pkg::result_t           result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sms_pkg::REG_W-1:0]  cfg_index,
    input  logic [sms_pkg::TOL_W-1:0]  cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [sms_pkg::DIM_W-1:0]  rows_reg, cols_reg;
    logic [sms_pkg::TOL_W-1:0]  tol_reg;
    logic [sms_pkg::ITER_W-1:0] maxit_reg;
    logic [sms_pkg::DIM_W-1:0]  nr, nc;

    sms_pkg::dp_cmd_t          cmd;
    sms_pkg::dp_stat_t         stat;
    logic [AW-1:0]             addr;
    logic [sms_pkg::DIM_W-1:0] line;
    logic                      cfg_we;

    // config is to be written only while idle (the user's duty; the block has no check), so always take it
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= sms_pkg::DIM_W'(16);
            cols_reg  <= sms_pkg::DIM_W'(16);
            tol_reg   <= sms_pkg::TOL_W'(4295);
            maxit_reg <= sms_pkg::ITER_W'(1000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sms_pkg::REG_ROWS:  rows_reg  <= cfg_data[sms_pkg::DIM_W-1:0];
                sms_pkg::REG_COLS:  cols_reg  <= cfg_data[sms_pkg::DIM_W-1:0];
                sms_pkg::REG_TOL:   tol_reg   <= cfg_data;
                sms_pkg::REG_MAXIT: maxit_reg <= cfg_data[sms_pkg::ITER_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp dimensions into 1..MAX
    assign nr = (rows_reg == '0) ? sms_pkg::DIM_W'(1)
              : (rows_reg > MAX_ROWS) ? sms_pkg::DIM_W'(MAX_ROWS) : rows_reg;
    assign nc = (cols_reg == '0) ? sms_pkg::DIM_W'(1)
              : (cols_reg > MAX_COLS) ? sms_pkg::DIM_W'(MAX_COLS) : cols_reg;

    sms_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .item       (item),
        .nr         (nr),
        .nc         (nc),
        .max_iter   (maxit_reg),
        .stat       (stat),
        .cmd        (cmd),
        .addr       (addr),
        .line       (line),
        .busy       (busy),
        .done       (done),
        .iterations (result.iterations),
        .status     (result.status)
    );

    sms_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .addr         (addr),
        .line         (line),
        .tolerance    (tol_reg),
        .stat         (stat),
        .result_value (result.result_value)
    );

endmodule

FILE: hw/rtl/sms_div.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sms_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sms_pkg::PROD_W-1:0] dividend,
    input  logic [sms_pkg::SUM_W-1:0]  divisor,
    output logic                       busy,
    output logic [sms_pkg::VAL_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(sms_pkg::VAL_W + 1);

    logic [sms_pkg::SUM_W-1:0] rem_reg, rem_next;
    logic [sms_pkg::VAL_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic [sms_pkg::SUM_W:0]   shifted;
    logic [sms_pkg::SUM_W:0]   diff;
    logic                      ge;

    // quotient is known to fit VAL_W bits, so the upper half seeds the remainder
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[sms_pkg::VAL_W-1]};
        ge        = shifted >= {1'b0, divisor};
        diff      = shifted - {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = sms_pkg::SUM_W'(dividend[sms_pkg::PROD_W-1:sms_pkg::VAL_W]);
            quo_next  = dividend[sms_pkg::VAL_W-1:0];
            cnt_next  = CNT_W'(sms_pkg::VAL_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[sms_pkg::SUM_W-1:0] : shifted[sms_pkg::SUM_W-1:0];
            quo_next  = {quo_reg[sms_pkg::VAL_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/sms_dp.sv
// Scaler datapath: matrix, snapshot and target memories, sums, multiplier, divider, error
`timescale 1ns / 1ps
module sms_dp #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16,
    localparam int DEPTH   = MAX_ROWS * MAX_COLS,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sms_pkg::item_t             item,
    input  sms_pkg::dp_cmd_t           cmd,
    input  logic [AW-1:0]              addr,
    input  logic [sms_pkg::DIM_W-1:0]  line,
    input  logic [sms_pkg::TOL_W-1:0]  tolerance,
    output sms_pkg::dp_stat_t          stat,
    output logic [sms_pkg::VAL_W-1:0]  result_value
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [sms_pkg::VAL_W-1:0] matrix_mem [DEPTH];
    logic [sms_pkg::VAL_W-1:0] snap_mem [DEPTH];
    logic [sms_pkg::VAL_W-1:0] row_tgt_mem [MAX_ROWS];
    logic [sms_pkg::VAL_W-1:0] col_tgt_mem [MAX_COLS];

    logic [sms_pkg::VAL_W-1:0]  mat_rd_reg, snap_rd_reg, row_rd_reg, col_rd_reg;
    logic [sms_pkg::SUM_W-1:0]  sum_reg;
    logic [sms_pkg::PROD_W-1:0] prod_reg;
    logic [sms_pkg::PROD_W-1:0] err_reg;
    logic [sms_pkg::PROD_W:0]   err_sum;
    logic [sms_pkg::VAL_W-1:0]  tgt, diff, op_a, op_b, quotient;
    logic [RW+sms_pkg::IDX_W-1:0] ld_row_ext;
    logic [CW+sms_pkg::IDX_W-1:0] ld_col_ext;
    logic [RW+sms_pkg::DIM_W-1:0] rd_row_ext;
    logic [CW+sms_pkg::DIM_W-1:0] rd_col_ext;
    logic                       div_busy;

    assign ld_row_ext = (RW + sms_pkg::IDX_W)'(item.index);
    assign ld_col_ext = (CW + sms_pkg::IDX_W)'(item.index);
    assign rd_row_ext = (RW + sms_pkg::DIM_W)'(line);
    assign rd_col_ext = (CW + sms_pkg::DIM_W)'(line);

    always_ff @(posedge clk)
    begin
        if (cmd.ld_mat)
            matrix_mem[addr] <= item.value;
        else if (cmd.mat_wr_q)
            matrix_mem[addr] <= quotient;
        mat_rd_reg <= matrix_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.snap_wr)
            snap_mem[addr] <= mat_rd_reg;
        snap_rd_reg <= snap_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_row)
            row_tgt_mem[ld_row_ext[RW-1:0]] <= item.value;
        row_rd_reg <= row_tgt_mem[rd_row_ext[RW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_col)
            col_tgt_mem[ld_col_ext[CW-1:0]] <= item.value;
        col_rd_reg <= col_tgt_mem[rd_col_ext[CW-1:0]];
    end

    assign tgt  = cmd.col_phase ? col_rd_reg : row_rd_reg;
    assign diff = (mat_rd_reg >= snap_rd_reg) ? (mat_rd_reg - snap_rd_reg)
                                              : (snap_rd_reg - mat_rd_reg);
    // one multiplier serves both the scale product and the squared change
    assign op_a = cmd.mul_sq ? diff : mat_rd_reg;
    assign op_b = cmd.mul_sq ? diff : tgt;

    always_ff @(posedge clk)
    begin
        if (cmd.mul_scale || cmd.mul_sq)
            prod_reg <= sms_pkg::PROD_W'(op_a) * sms_pkg::PROD_W'(op_b);
    end

    assign err_sum = {1'b0, err_reg} + {1'b0, prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            err_reg <= '0;
        end
        else
        begin
            if (cmd.sum_clr)
                sum_reg <= '0;
            else if (cmd.sum_acc)
                sum_reg <= sum_reg + sms_pkg::SUM_W'(mat_rd_reg);
            if (cmd.err_clr)
                err_reg <= '0;
            else if (cmd.err_acc)
                err_reg <= err_sum[sms_pkg::PROD_W] ? '1 : err_sum[sms_pkg::PROD_W-1:0];
        end
    end

    sms_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (sum_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign stat.sum_zero  = sum_reg == '0;
    assign stat.converged = err_reg < sms_pkg::PROD_W'(tolerance);
    assign stat.div_busy  = div_busy;

    assign result_value = (cmd.show_read && !cmd.read_bad) ? mat_rd_reg : '0;

endmodule

FILE: hw/rtl/sms_ctrl.sv
// Scaler controller: command decode, pass sequencing and iteration control
`timescale 1ns / 1ps
module sms_ctrl #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16,
    localparam int DEPTH   = MAX_ROWS * MAX_COLS,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  sms_pkg::item_t             item,
    input  logic [sms_pkg::DIM_W-1:0]  nr,
    input  logic [sms_pkg::DIM_W-1:0]  nc,
    input  logic [sms_pkg::ITER_W-1:0] max_iter,
    input  sms_pkg::dp_stat_t          stat,
    output sms_pkg::dp_cmd_t           cmd,
    output logic [AW-1:0]              addr,
    output logic [sms_pkg::DIM_W-1:0]  line,
    output logic                       busy,
    output logic                       done,
    output logic [sms_pkg::ITER_W-1:0] iterations,
    output logic [sms_pkg::STAT_W-1:0] status
);

    localparam int SW    = 5;

    localparam logic [SW-1:0] S_IDLE     = 5'd0;
    localparam logic [SW-1:0] S_READ_RD  = 5'd1;
    localparam logic [SW-1:0] S_READ_OUT = 5'd2;
    localparam logic [SW-1:0] S_SNAP_RD  = 5'd3;
    localparam logic [SW-1:0] S_SNAP_WR  = 5'd4;
    localparam logic [SW-1:0] S_SUM_RD   = 5'd5;
    localparam logic [SW-1:0] S_SUM_ACC  = 5'd6;
    localparam logic [SW-1:0] S_CHECK    = 5'd7;
    localparam logic [SW-1:0] S_SCL_RD   = 5'd8;
    localparam logic [SW-1:0] S_SCL_MUL  = 5'd9;
    localparam logic [SW-1:0] S_SCL_GO   = 5'd10;
    localparam logic [SW-1:0] S_SCL_DIV  = 5'd11;
    localparam logic [SW-1:0] S_ERR_RD   = 5'd12;
    localparam logic [SW-1:0] S_ERR_MUL  = 5'd13;
    localparam logic [SW-1:0] S_ERR_ACC  = 5'd14;
    localparam logic [SW-1:0] S_ITER_END = 5'd15;
    localparam logic [SW-1:0] S_DONE     = 5'd16;

    logic [SW-1:0]                 state_reg, state_next;
    logic [sms_pkg::FLAT_W-1:0]    k_reg, k_next;
    logic [sms_pkg::DIM_W-1:0]     line_reg, line_next, elem_reg, elem_next;
    logic                          col_reg, col_next;
    logic [sms_pkg::ITER_W-1:0]    iter_reg, iter_next;
    logic                          zero_reg, zero_next;
    logic [sms_pkg::STAT_W-1:0]    stat_reg, stat_sel;
    logic [sms_pkg::IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                          bad_reg, bad_next;

    logic [sms_pkg::FLAT_W-1:0]    total, line_addr, flat;
    logic [sms_pkg::FLAT_W+AW-1:0] flat_ext;
    logic [sms_pkg::DIM_W-1:0]     row, col, n_elem, n_lines;
    logic [sms_pkg::ITER_W-1:0]    cap;
    logic                          adv_line, last_k, last_elem;

    assign total     = sms_pkg::FLAT_W'(nr) * sms_pkg::FLAT_W'(nc);
    assign row       = col_reg ? elem_reg : line_reg;
    assign col       = col_reg ? line_reg : elem_reg;
    assign line_addr = sms_pkg::FLAT_W'(row) * sms_pkg::FLAT_W'(nc) + sms_pkg::FLAT_W'(col);
    assign n_elem    = col_reg ? nr : nc;
    assign n_lines   = col_reg ? nc : nr;
    assign cap       = (max_iter == '0) ? sms_pkg::ITER_W'(1) : max_iter;
    assign last_k    = k_reg == total - sms_pkg::FLAT_W'(1);
    assign last_elem = elem_reg == n_elem - sms_pkg::DIM_W'(1);

    always_comb
    begin
        case (state_reg)
            S_IDLE:                         flat = sms_pkg::FLAT_W'(item.index);
            S_READ_RD, S_READ_OUT:          flat = sms_pkg::FLAT_W'(rd_idx_reg);
            S_SNAP_RD, S_SNAP_WR, S_ERR_RD,
            S_ERR_MUL, S_ERR_ACC:           flat = k_reg;
            default:                        flat = line_addr;
        endcase
    end

    assign flat_ext = (sms_pkg::FLAT_W + AW)'(flat);
    assign addr     = flat_ext[AW-1:0];
    assign line     = line_reg;

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        line_next   = line_reg;
        elem_next   = elem_reg;
        col_next    = col_reg;
        iter_next   = iter_reg;
        zero_next   = zero_reg;
        stat_sel    = stat_reg;
        rd_idx_next = rd_idx_reg;
        bad_next    = bad_reg;
        adv_line    = 1'b0;
        cmd         = '0;
        cmd.col_phase = col_reg;
        done        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (item.mode)
                        sms_pkg::MODE_LD_ENTRY:
                            cmd.ld_mat = sms_pkg::FLAT_W'(item.index) < total;
                        sms_pkg::MODE_LD_ROW:
                            cmd.ld_row = item.index < MAX_ROWS;
                        sms_pkg::MODE_LD_COL:
                            cmd.ld_col = item.index < MAX_COLS;
                        sms_pkg::MODE_RUN:
                        begin
                            iter_next  = sms_pkg::ITER_W'(1);
                            zero_next  = 1'b0;
                            k_next     = '0;
                            state_next = S_SNAP_RD;
                        end
                        sms_pkg::MODE_READ:
                        begin
                            rd_idx_next = item.index;
                            bad_next    = sms_pkg::FLAT_W'(item.index) >= total;
                            state_next  = S_READ_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ_RD:
                state_next = S_READ_OUT;
            S_READ_OUT:
            begin
                cmd.show_read = 1'b1;
                cmd.read_bad  = bad_reg;
                done          = 1'b1;
                state_next    = S_IDLE;
            end
            S_SNAP_RD:
                state_next = S_SNAP_WR;
            S_SNAP_WR:
            begin
                cmd.snap_wr = 1'b1;
                if (last_k)
                begin
                    col_next    = 1'b0;
                    line_next   = '0;
                    elem_next   = '0;
                    cmd.sum_clr = 1'b1;
                    state_next  = S_SUM_RD;
                end
                else
                begin
                    k_next     = k_reg + sms_pkg::FLAT_W'(1);
                    state_next = S_SNAP_RD;
                end
            end
            S_SUM_RD:
                state_next = S_SUM_ACC;
            S_SUM_ACC:
            begin
                cmd.sum_acc = 1'b1;
                if (last_elem)
                begin
                    elem_next  = '0;
                    state_next = S_CHECK;
                end
                else
                begin
                    elem_next  = elem_reg + sms_pkg::DIM_W'(1);
                    state_next = S_SUM_RD;
                end
            end
            S_CHECK:
            begin
                if (stat.sum_zero)
                begin
                    zero_next = 1'b1;
                    adv_line  = 1'b1;
                end
                else
                    state_next = S_SCL_RD;
            end
            S_SCL_RD:
                state_next = S_SCL_MUL;
            S_SCL_MUL:
            begin
                cmd.mul_scale = 1'b1;
                state_next    = S_SCL_GO;
            end
            S_SCL_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_SCL_DIV;
            end
            S_SCL_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.mat_wr_q = 1'b1;
                    if (last_elem)
                        adv_line = 1'b1;
                    else
                    begin
                        elem_next  = elem_reg + sms_pkg::DIM_W'(1);
                        state_next = S_SCL_RD;
                    end
                end
            end
            S_ERR_RD:
                state_next = S_ERR_MUL;
            S_ERR_MUL:
            begin
                cmd.mul_sq = 1'b1;
                state_next = S_ERR_ACC;
            end
            S_ERR_ACC:
            begin
                cmd.err_acc = 1'b1;
                if (last_k)
                    state_next = S_ITER_END;
                else
                begin
                    k_next     = k_reg + sms_pkg::FLAT_W'(1);
                    state_next = S_ERR_RD;
                end
            end
            S_ITER_END:
            begin
                if (stat.converged)
                begin
                    stat_sel   = zero_reg ? sms_pkg::STAT_ZERO : sms_pkg::STAT_OK;
                    state_next = S_DONE;
                end
                else if (iter_reg == cap)
                begin
                    stat_sel   = zero_reg ? sms_pkg::STAT_ZERO : sms_pkg::STAT_CAP;
                    state_next = S_DONE;
                end
                else
                begin
                    iter_next  = iter_reg + sms_pkg::ITER_W'(1);
                    k_next     = '0;
                    state_next = S_SNAP_RD;
                end
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        // next line, next phase, or on to the error pass
        if (adv_line)
        begin
            elem_next = '0;
            if (line_reg == n_lines - sms_pkg::DIM_W'(1))
            begin
                if (!col_reg)
                begin
                    col_next    = 1'b1;
                    line_next   = '0;
                    cmd.sum_clr = 1'b1;
                    state_next  = S_SUM_RD;
                end
                else
                begin
                    k_next      = '0;
                    cmd.err_clr = 1'b1;
                    state_next  = S_ERR_RD;
                end
            end
            else
            begin
                line_next   = line_reg + sms_pkg::DIM_W'(1);
                cmd.sum_clr = 1'b1;
                state_next  = S_SUM_RD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            k_reg      <= '0;
            line_reg   <= '0;
            elem_reg   <= '0;
            col_reg    <= 1'b0;
            iter_reg   <= '0;
            zero_reg   <= 1'b0;
            stat_reg   <= sms_pkg::STAT_OK;
            rd_idx_reg <= '0;
            bad_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            line_reg   <= line_next;
            elem_reg   <= elem_next;
            col_reg    <= col_next;
            iter_reg   <= iter_next;
            zero_reg   <= zero_next;
            stat_reg   <= stat_sel;
            rd_idx_reg <= rd_idx_next;
            bad_reg    <= bad_next;
        end
    end

    assign busy       = state_reg != S_IDLE;
    assign iterations = iter_reg;
    assign status     = (state_reg == S_READ_OUT)
                        ? (bad_reg ? sms_pkg::STAT_BAD : sms_pkg::STAT_OK)
                        : stat_reg;

endmodule

FILE: hw/rtl/sms_checker.sv
// Port-level checker for the scaler, bound to the top level
`timescale 1ns / 1ps
`include "sinkhorn_matrix_scaler_unit_defines.svh"
module sms_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input sms_pkg::item_t   item,
    input logic             done,
    input sms_pkg::result_t result
);

    `SMS_ASSERT_NOW(a_done_while_busy, done, busy, "result strobe while idle")
    `SMS_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `SMS_ASSERT_NEXT(a_cmd_blocks, start && !busy && (item.mode == sms_pkg::MODE_RUN || item.mode == sms_pkg::MODE_READ), busy, "run or read did not raise busy")
    `SMS_ASSERT_NEXT(a_load_free, start && !busy && (item.mode == sms_pkg::MODE_LD_ENTRY || item.mode == sms_pkg::MODE_LD_ROW || item.mode == sms_pkg::MODE_LD_COL), !busy && !done, "load stalled or gave a result")
    `SMS_ASSERT_NOW(a_bad_zero, done && result.status == sms_pkg::STAT_BAD, result.result_value == '0, "bad index with nonzero value")

endmodule

bind sinkhorn_matrix_scaler_unit sms_checker u_sms_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
